// ===== design/srts_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the
// shortest-remaining-time scheduler; no dependencies
package srts_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int WAIT_W  = 24;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    // command codes on the input tuser
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // status codes on the output tuser
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;           // capture input beat
        logic exec;           // apply captured item to the cell chain
        logic out_from_res;   // result into output register
        logic skid_from_res;  // result into skid register
        logic out_from_skid;  // skid register into output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic res_valid;      // the item under execution yields a result
    } dp_stat_t;

endpackage

// ===== design/srts_ctrl.sv =====
// controller for the scheduler: two-state sequencer plus output and skid
// occupancy tracking; depends on srts_pkg
module srts_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output srts_pkg::dp_cmd_t   cmd,
    input  srts_pkg::dp_stat_t  stat
);

    localparam logic ST_READY = 1'b0;
    localparam logic ST_EXEC  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic in_acc;
    logic out_take;

    assign in_ready  = (state_reg == ST_READY) && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_take;
        skid_valid_next = skid_valid_reg;
        cmd.load        = in_acc;

        case (state_reg)
            ST_READY:
            begin
                if (in_acc)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_READY;
                if (stat.res_valid)
                begin
                    if (!out_valid_reg || out_take)
                    begin
                        cmd.out_from_res = 1'b1;
                    end
                    else
                    begin
                        cmd.skid_from_res = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase

        // drain skid once the output register frees up
        if (skid_valid_reg && (!out_valid_reg || out_take))
        begin
            cmd.out_from_skid = 1'b1;
        end

        if (cmd.out_from_res || cmd.out_from_skid)
        begin
            out_valid_next = 1'b1;
        end
        if (cmd.skid_from_res)
        begin
            skid_valid_next = 1'b1;
        end
        else if (cmd.out_from_skid)
        begin
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_READY;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // skid only holds a beat behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    // an item only executes with the skid free for its result
    a_exec_skid_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !skid_valid_reg)
        else $error("execution with no room for a result");

    // an accepted beat executes on the next cycle
    a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

    // result never collides with a pending skid drain
    a_no_double_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_from_res && cmd.out_from_skid))
        else $error("two sources load the output register");

endmodule

// ===== design/srts_dp.sv =====
// datapath for the scheduler: input capture, sorted chain of job cells,
// result formation and output/skid registers; depends on srts_pkg
module srts_dp #(
    parameter int QUEUE_DEPTH = srts_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  srts_pkg::dp_cmd_t            cmd,
    output srts_pkg::dp_stat_t           stat,
    input  logic                         in_command,
    input  logic [srts_pkg::ID_W-1:0]    in_job_id,
    input  logic [srts_pkg::BURST_W-1:0] in_burst,
    output logic                         status,
    output logic [srts_pkg::ID_W-1:0]    job_id_out,
    output logic [srts_pkg::WAIT_W-1:0]  waiting_time
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

    // captured item
    logic                         cmd_reg;
    logic [srts_pkg::ID_W-1:0]    id_reg;
    logic [srts_pkg::BURST_W-1:0] burst_reg;

    // job cells, head at index zero
    logic [srts_pkg::ID_W-1:0]    id_q    [QUEUE_DEPTH];
    logic [srts_pkg::BURST_W-1:0] rem_q   [QUEUE_DEPTH];
    logic [srts_pkg::WAIT_W-1:0]  wait_q  [QUEUE_DEPTH];
    logic [srts_pkg::ID_W-1:0]    id_next   [QUEUE_DEPTH];
    logic [srts_pkg::BURST_W-1:0] rem_next  [QUEUE_DEPTH];
    logic [srts_pkg::WAIT_W-1:0]  wait_next [QUEUE_DEPTH];
    logic [srts_pkg::WAIT_W-1:0]  wait_inc  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]       le;

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    logic full;
    logic ins_go;
    logic tick_go;
    logic pop;
    logic reject;

    logic                        res_status;
    logic [srts_pkg::ID_W-1:0]   res_id;
    logic [srts_pkg::WAIT_W-1:0] res_wait;

    logic                        skid_status_reg;
    logic [srts_pkg::ID_W-1:0]   skid_id_reg;
    logic [srts_pkg::WAIT_W-1:0] skid_wait_reg;
    logic                        out_status_reg;
    logic [srts_pkg::ID_W-1:0]   out_id_reg;
    logic [srts_pkg::WAIT_W-1:0] out_wait_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= in_command;
            id_reg    <= in_job_id;
            burst_reg <= in_burst;
        end
    end

    assign full    = (occ_reg == OCC_FULL);
    assign ins_go  = cmd.exec && (cmd_reg == srts_pkg::CMD_ARRIVE)
                     && (burst_reg != '0) && !full;
    assign reject  = (cmd_reg == srts_pkg::CMD_ARRIVE) && (burst_reg != '0) && full;
    assign tick_go = cmd.exec && (cmd_reg == srts_pkg::CMD_TICK) && (occ_reg != '0);
    assign pop     = tick_go && (rem_q[0] == srts_pkg::BURST_W'(1));

    assign stat.res_valid = cmd.exec && (reject || pop);

    assign res_status = reject ? srts_pkg::STATUS_REJECT : srts_pkg::STATUS_DONE;
    assign res_id     = reject ? id_reg : id_q[0];
    assign res_wait   = reject ? '0 : wait_q[0];

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            logic                         prev_le;
            logic [srts_pkg::ID_W-1:0]    up_id;
            logic [srts_pkg::BURST_W-1:0] up_rem;
            logic [srts_pkg::WAIT_W-1:0]  up_wait;
            logic [srts_pkg::ID_W-1:0]    dn_id;
            logic [srts_pkg::BURST_W-1:0] dn_rem;
            logic [srts_pkg::WAIT_W-1:0]  dn_wait;

            // valid cell that stays ahead of the arrival
            assign le[k] = (OCC_W'(k) < occ_reg) && (rem_q[k] <= burst_reg);
            assign wait_inc[k] = (wait_q[k] == srts_pkg::WAIT_MAX) ? wait_q[k]
                                 : wait_q[k] + srts_pkg::WAIT_W'(1);

            if (k == 0)
            begin : g_head
                assign prev_le = 1'b1;
                assign up_id   = id_reg;
                assign up_rem  = burst_reg;
                assign up_wait = '0;
            end
            else
            begin : g_body
                assign prev_le = le[k-1];
                assign up_id   = id_q[k-1];
                assign up_rem  = rem_q[k-1];
                assign up_wait = wait_q[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_tail
                assign dn_id   = id_q[k];
                assign dn_rem  = rem_q[k];
                assign dn_wait = wait_q[k];
            end
            else
            begin : g_inner
                assign dn_id   = id_q[k+1];
                assign dn_rem  = rem_q[k+1];
                assign dn_wait = wait_inc[k+1];
            end

            // insert: keep, take the new job, or shift down from above
            // pop: shift up with the waiting count already advanced
            assign id_next[k] =
                ins_go ? (le[k] ? id_q[k] : (prev_le ? id_reg : up_id)) :
                pop    ? dn_id : id_q[k];

            assign rem_next[k] =
                ins_go ? (le[k] ? rem_q[k] : (prev_le ? burst_reg : up_rem)) :
                pop    ? dn_rem :
                (tick_go && (k == 0)) ? rem_q[k] - srts_pkg::BURST_W'(1) : rem_q[k];

            assign wait_next[k] =
                ins_go ? (le[k] ? wait_q[k] : (prev_le ? '0 : up_wait)) :
                pop    ? dn_wait :
                (tick_go && (k != 0)) ? wait_inc[k] : wait_q[k];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            id_q[i]   <= id_next[i];
            rem_q[i]  <= rem_next[i];
            wait_q[i] <= wait_next[i];
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (ins_go)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (pop)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // result staging
    always_ff @(posedge clk)
    begin
        if (cmd.skid_from_res)
        begin
            skid_status_reg <= res_status;
            skid_id_reg     <= res_id;
            skid_wait_reg   <= res_wait;
        end
        if (cmd.out_from_res)
        begin
            out_status_reg <= res_status;
            out_id_reg     <= res_id;
            out_wait_reg   <= res_wait;
        end
        else if (cmd.out_from_skid)
        begin
            out_status_reg <= skid_status_reg;
            out_id_reg     <= skid_id_reg;
            out_wait_reg   <= skid_wait_reg;
        end
    end

    assign status       = out_status_reg;
    assign job_id_out   = out_id_reg;
    assign waiting_time = out_wait_reg;

endmodule

// ===== design/shortest_remaining_time_scheduler_core.sv =====
// top level of the preemptive shortest-remaining-time scheduler
// depends on srts_pkg, srts_ctrl and srts_dp
//
// usage
//   slave channel: one beat is one event. tuser selects the event
//     (arrival or tick); tdata carries job id and burst for an arrival
//   master channel: one beat per finished job (status done, its waiting
//     ticks) or per arrival rejected on a full queue (status reject)
//   an arrival with burst zero and a tick on an empty queue give no beat
//   the queue is a chain of QUEUE_DEPTH cells sorted by remaining time;
//     every cell compares and shifts in parallel, so each event is applied
//     in the execute state of the controller
//   result path: an accepted beat is captured at the accepting edge, applied
//     in the execute state and registered into the output or skid register
//   sequencing: no new event is taken while one executes; the controller
//     alternates between its capture and execute states
//   stall: results sit in an output register backed by a one-beat skid
//     register; input is taken while the skid is free, so one result may
//     wait unaccepted without holding up the next event
//   reset: rst_n clears the queue to empty and drops any pending beats
module shortest_remaining_time_scheduler_core #(
    parameter int QUEUE_DEPTH = srts_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // job_id [7:0], burst [23:8]
    input  logic [0:0]  s_axis_tuser,   // command [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // job_id_out [7:0], waiting_time [31:8]
    output logic [0:0]  m_axis_tuser    // status [0]
);

    srts_pkg::dp_cmd_t  dp_cmd;
    srts_pkg::dp_stat_t dp_stat;

    logic                        res_status;
    logic [srts_pkg::ID_W-1:0]   res_id;
    logic [srts_pkg::WAIT_W-1:0] res_wait;

    // sequencing and output handshake
    srts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    // sorted job chain and result registers
    srts_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .in_command   (s_axis_tuser[0]),
        .in_job_id    (s_axis_tdata[7:0]),
        .in_burst     (s_axis_tdata[23:8]),
        .status       (res_status),
        .job_id_out   (res_id),
        .waiting_time (res_wait)
    );

    assign m_axis_tdata = {res_wait, res_id};
    assign m_axis_tuser = res_status;

endmodule
